// ===== rtl/dsp_pkg.sv =====
// Shared types and constants for the dual servo PWM register slave.
`timescale 1ns / 1ps

package dsp_pkg;

    // Register map and status bit
    localparam logic [7:0] ADDR_STATUS = 8'd0;
    localparam logic [7:0] ADDR_STD_A  = 8'd1;
    localparam logic [7:0] ADDR_STD_B  = 8'd2;
    localparam logic [7:0] ADDR_EXT_A  = 8'd3;
    localparam logic [7:0] ADDR_EXT_B  = 8'd4;
    localparam int unsigned ENABLE_BIT = 0;

    // Position scaling offsets and reset values
    localparam logic [15:0] STD_OFS   = 16'd544;
    localparam logic [15:0] EXT_OFS   = 16'd288;
    localparam logic [15:0] TOP_RESET = 16'd10347;
    localparam logic [15:0] CMP_RESET = 16'd800;

    // Kind of event carried by one input word
    typedef enum logic [1:0] {
        MODE_TICK  = 2'd0,
        MODE_WRITE = 2'd1,
        MODE_PTR   = 2'd2,
        MODE_READ  = 2'd3
    } t_mode;

    typedef struct packed {
        t_mode      mode;
        logic [7:0] reg_index;
        logic [7:0] write_data;
    } t_item;

    // Pending compare values handed from the register map to the PWM timer
    typedef struct packed {
        logic [15:0] cmp_a;
        logic [15:0] cmp_b;
    } t_pend;

endpackage

// ===== rtl/dsp_intf.sv =====
// Valid/ready channel interfaces for input events and result words.
`timescale 1ns / 1ps

interface dsp_item_if;
    logic       valid;
    logic       ready;
    logic [1:0] mode;
    logic [7:0] reg_index;
    logic [7:0] write_data;

    modport source (output valid, output mode, output reg_index, output write_data,
                    input ready);
    modport sink   (input valid, input mode, input reg_index, input write_data,
                    output ready);
endinterface

interface dsp_result_if;
    logic       valid;
    logic       ready;
    logic [7:0] read_data;
    logic       servo_a_level;
    logic       servo_b_level;
    logic       drive_enable;

    modport source (output valid, output read_data, output servo_a_level,
                    output servo_b_level, output drive_enable, input ready);
    modport sink   (input valid, input read_data, input servo_a_level,
                    input servo_b_level, input drive_enable, output ready);
endinterface

// ===== rtl/dsp_regs.sv =====
// Byte register map: status, position registers, read pointer and bus byte.
`timescale 1ns / 1ps

module dsp_regs (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_step,
    input  dsp_pkg::t_item i_item,
    output dsp_pkg::t_pend o_pend,
    output logic [7:0]     o_last_byte,
    output logic           o_drive_en
);
    import dsp_pkg::*;

    logic [7:0]  r_status, n_status;
    logic [15:0] r_pend_a, n_pend_a;
    logic [15:0] r_pend_b, n_pend_b;
    logic [7:0]  r_ptr, n_ptr;
    logic [7:0]  r_last, n_last;

    logic [15:0] w_std_val;
    logic [15:0] w_ext_val;
    logic [15:0] w_diff_std_a;
    logic [15:0] w_diff_std_b;
    logic [15:0] w_diff_ext_a;
    logic [15:0] w_diff_ext_b;
    logic [7:0]  w_rd;

    // Scale a written position byte into a compare value
    assign w_std_val = STD_OFS + {7'd0, i_item.write_data, 1'b0};
    assign w_ext_val = EXT_OFS + {6'd0, i_item.write_data, 2'b00};

    // Undo the scaling for read-back: difference from the offset, shifted down, low byte
    assign w_diff_std_a = r_pend_a - STD_OFS;
    assign w_diff_std_b = r_pend_b - STD_OFS;
    assign w_diff_ext_a = r_pend_a - EXT_OFS;
    assign w_diff_ext_b = r_pend_b - EXT_OFS;

    // Decode the read pointer
    always_comb begin
        unique case (r_ptr)
            ADDR_STATUS: w_rd = r_status;
            ADDR_STD_A:  w_rd = w_diff_std_a[8:1];
            ADDR_STD_B:  w_rd = w_diff_std_b[8:1];
            ADDR_EXT_A:  w_rd = w_diff_ext_a[9:2];
            ADDR_EXT_B:  w_rd = w_diff_ext_b[9:2];
            default:     w_rd = r_last;
        endcase
    end

    // Apply one event to the register map
    always_comb begin
        n_status = r_status;
        n_pend_a = r_pend_a;
        n_pend_b = r_pend_b;
        n_ptr    = r_ptr;
        n_last   = r_last;
        if (i_step) begin
            unique case (i_item.mode)
                MODE_TICK: begin
                end
                MODE_WRITE: begin
                    unique case (i_item.reg_index)
                        ADDR_STATUS: n_status = i_item.write_data;
                        ADDR_STD_A:  n_pend_a = w_std_val;
                        ADDR_STD_B:  n_pend_b = w_std_val;
                        ADDR_EXT_A:  n_pend_a = w_ext_val;
                        ADDR_EXT_B:  n_pend_b = w_ext_val;
                        default:     n_status = r_status;
                    endcase
                    n_last = i_item.write_data;
                end
                MODE_PTR: begin
                    n_ptr  = i_item.reg_index;
                    n_last = i_item.reg_index;
                end
                MODE_READ: begin
                    n_last = w_rd;
                end
            endcase
        end
    end

    // Hold register state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_status <= 8'd0;
            r_pend_a <= CMP_RESET;
            r_pend_b <= CMP_RESET;
            r_ptr    <= 8'd0;
            r_last   <= 8'd0;
        end else begin
            r_status <= n_status;
            r_pend_a <= n_pend_a;
            r_pend_b <= n_pend_b;
            r_ptr    <= n_ptr;
            r_last   <= n_last;
        end
    end

    assign o_pend.cmp_a = r_pend_a;
    assign o_pend.cmp_b = r_pend_b;
    assign o_last_byte  = n_last;
    assign o_drive_en   = n_status[ENABLE_BIT];

endmodule

// ===== rtl/dsp_pwm.sv =====
// Phase and frequency correct up/down timer with two compare channels.
`timescale 1ns / 1ps

module dsp_pwm (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_tick,
    input  logic [15:0]    i_top,
    input  dsp_pkg::t_pend i_pend,
    output logic           o_level_a,
    output logic           o_level_b
);
    import dsp_pkg::*;

    logic [15:0] r_cnt, n_cnt;
    logic        r_down, n_down;
    logic [15:0] r_act_a, n_act_a;
    logic [15:0] r_act_b, n_act_b;

    logic [15:0] w_cnt_up;
    logic [15:0] w_cnt_dn;

    // Step the count, saturating at the top and at zero
    assign w_cnt_up = (r_cnt < i_top) ? (r_cnt + 16'd1) : r_cnt;
    assign w_cnt_dn = (r_cnt != 16'd0) ? (r_cnt - 16'd1) : r_cnt;

    // Turn at the top; reload compares and turn at the bottom
    always_comb begin
        n_cnt   = r_cnt;
        n_down  = r_down;
        n_act_a = r_act_a;
        n_act_b = r_act_b;
        if (i_tick) begin
            if (!r_down) begin
                n_cnt = w_cnt_up;
                if (w_cnt_up >= i_top) begin
                    n_down = 1'b1;
                end
            end else begin
                n_cnt = w_cnt_dn;
                if (w_cnt_dn == 16'd0) begin
                    n_down  = 1'b0;
                    n_act_a = i_pend.cmp_a;
                    n_act_b = i_pend.cmp_b;
                end
            end
        end
    end

    // Hold timer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt   <= 16'd0;
            r_down  <= 1'b0;
            r_act_a <= CMP_RESET;
            r_act_b <= CMP_RESET;
        end else begin
            r_cnt   <= n_cnt;
            r_down  <= n_down;
            r_act_a <= n_act_a;
            r_act_b <= n_act_b;
        end
    end

    // Output levels as they stand after this event
    assign o_level_a = (n_cnt < n_act_a);
    assign o_level_b = (n_cnt < n_act_b);

endmodule

// ===== rtl/dual_servo_pwm_register_slave.sv =====
// Top level: input register, register map, PWM timer and result register.
// Flow: a word taken into the input register is processed once the result register
//   is free or draining, and its result word is then loaded into the result register.
// Throughput: one word per cycle; while a result word waits, one more input word
//   is held in the input register and further input stalls until it drains.
// Reset: synchronous, active low; registers, compares and the counter top take their
//   reset values and both channels come up empty.
`timescale 1ns / 1ps

module dual_servo_pwm_register_slave (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic [15:0]   i_cfg_wdata,
    dsp_item_if.sink      i_item,
    dsp_result_if.source  o_result
);
    import dsp_pkg::*;

    logic        r_in_valid;
    t_item       r_in;
    logic        r_out_valid;
    logic [7:0]  r_rd;
    logic        r_lvl_a;
    logic        r_lvl_b;
    logic        r_drv;
    logic [15:0] r_top;

    logic        w_step;
    logic        w_tick;
    t_pend       w_pend;
    logic [7:0]  w_last;
    logic        w_drv;
    logic        w_lvl_a;
    logic        w_lvl_b;

    // Process the held word when the result register is free or draining
    assign w_step       = r_in_valid && (!r_out_valid || o_result.ready);
    assign w_tick       = w_step && (r_in.mode == MODE_TICK);
    assign i_item.ready = !r_in_valid || w_step;

    // Capture the input word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_item.valid && i_item.ready) begin
            r_in_valid <= 1'b1;
        end else if (w_step) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_item.valid && i_item.ready) begin
            r_in.mode       <= t_mode'(i_item.mode);
            r_in.reg_index  <= i_item.reg_index;
            r_in.write_data <= i_item.write_data;
        end
    end

    // Hold the counter turning point
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_top <= TOP_RESET;
        end else if (i_cfg_we) begin
            r_top <= i_cfg_wdata;
        end
    end

    dsp_regs u_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (w_step),
        .i_item      (r_in),
        .o_pend      (w_pend),
        .o_last_byte (w_last),
        .o_drive_en  (w_drv)
    );

    dsp_pwm u_pwm (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_tick    (w_tick),
        .i_top     (r_top),
        .i_pend    (w_pend),
        .o_level_a (w_lvl_a),
        .o_level_b (w_lvl_b)
    );

    // Load the result word, drop it once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_step) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_rd    <= w_last;
            r_lvl_a <= w_lvl_a;
            r_lvl_b <= w_lvl_b;
            r_drv   <= w_drv;
        end
    end

    assign o_result.valid         = r_out_valid;
    assign o_result.read_data     = r_rd;
    assign o_result.servo_a_level = r_lvl_a;
    assign o_result.servo_b_level = r_lvl_b;
    assign o_result.drive_enable  = r_drv;

endmodule

// ===== rtl/dsp_checker.sv =====
// Port-level checks on the servo register slave, attached by bind.
`timescale 1ns / 1ps

module dsp_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_ready,
    input  logic       i_out_valid,
    input  logic       i_out_ready,
    input  logic [7:0] i_out_rd,
    input  logic       i_out_a,
    input  logic       i_out_b,
    input  logic       i_out_drv
);

    // Reset empties the result channel
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    // An empty result stage never stalls input
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input stalled with empty result stage");

    // Every accepted word is followed by a valid word on the result channel
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |-> ##2 i_out_valid)
        else $error("no result after accepted word");

    // A stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_out_rd) && $stable(i_out_a)
             && $stable(i_out_b) && $stable(i_out_drv)))
        else $error("stalled result word changed");

endmodule

bind dual_servo_pwm_register_slave dsp_checker u_dsp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_item.valid),
    .i_in_ready  (i_item.ready),
    .i_out_valid (o_result.valid),
    .i_out_ready (o_result.ready),
    .i_out_rd    (o_result.read_data),
    .i_out_a     (o_result.servo_a_level),
    .i_out_b     (o_result.servo_b_level),
    .i_out_drv   (o_result.drive_enable)
);

// ===== test/dual_servo_pwm_register_slave_tb.sv =====
// Self-checking testbench for the dual servo PWM register slave.
`timescale 1ns / 1ps

module dual_servo_pwm_register_slave_tb;
    import dsp_pkg::*;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int SETTLE_CYCLES = 4;
    localparam int PRINT_CAP     = 100;

    typedef struct packed {
        logic [7:0] read_data;
        logic       level_a;
        logic       level_b;
        logic       drive_en;
    } t_servo_word;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [15:0] i_cfg_wdata;

    dsp_item_if   item_if ();
    dsp_result_if result_if ();

    dual_servo_pwm_register_slave uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_item      (item_if),
        .o_result    (result_if)
    );

    // Predicted block state
    logic [15:0] servo_top;
    logic [15:0] pend_a;
    logic [15:0] pend_b;
    logic [15:0] act_a;
    logic [15:0] act_b;
    logic [15:0] pwm_count;
    bit          pwm_down;
    logic [7:0]  status_reg;
    logic [7:0]  read_ptr;
    logic [7:0]  bus_byte;

    t_item       pending_words[$];
    t_servo_word expected_words[$];

    int  mismatch_count = 0;
    int  cycle_count    = 0;
    int  send_idle_pct  = 14;
    int  recv_stall_pct = 79;
    bit  word_taken     = 0;
    bit  was_taken;

    always #4 i_clk = ~i_clk;

    // Move the PWM counter one step, reloading compares at the bottom
    function automatic void advance_count();
        if (!pwm_down) begin
            if (pwm_count < servo_top)
                pwm_count = pwm_count + 16'd1;
            if (pwm_count >= servo_top)
                pwm_down = 1'b1;
        end else begin
            if (pwm_count > 16'd0)
                pwm_count = pwm_count - 16'd1;
            if (pwm_count == 16'd0) begin
                pwm_down = 1'b0;
                act_a    = pend_a;
                act_b    = pend_b;
            end
        end
    endfunction

    // Difference from the offset, shifted right, low byte kept
    function automatic logic [7:0] position_byte(logic [15:0] cmp, logic [15:0] ofs,
                                                 int unsigned sh);
        logic [15:0] diff;
        logic [15:0] shifted;
        diff    = cmp - ofs;
        shifted = diff >> sh;
        return shifted[7:0];
    endfunction

    // Apply one accepted word to the predicted state and form its result
    function automatic t_servo_word apply_word(t_item w);
        logic [7:0]  rd;
        t_servo_word r;
        case (w.mode)
            MODE_TICK: advance_count();
            MODE_WRITE: begin
                case (w.reg_index)
                    ADDR_STATUS: status_reg = w.write_data;
                    ADDR_STD_A:  pend_a = STD_OFS + {7'd0, w.write_data, 1'b0};
                    ADDR_STD_B:  pend_b = STD_OFS + {7'd0, w.write_data, 1'b0};
                    ADDR_EXT_A:  pend_a = EXT_OFS + {6'd0, w.write_data, 2'b00};
                    ADDR_EXT_B:  pend_b = EXT_OFS + {6'd0, w.write_data, 2'b00};
                    default: ;
                endcase
                bus_byte = w.write_data;
            end
            MODE_PTR: begin
                read_ptr = w.reg_index;
                bus_byte = w.reg_index;
            end
            default: begin
                case (read_ptr)
                    ADDR_STATUS: rd = status_reg;
                    ADDR_STD_A:  rd = position_byte(pend_a, STD_OFS, 1);
                    ADDR_STD_B:  rd = position_byte(pend_b, STD_OFS, 1);
                    ADDR_EXT_A:  rd = position_byte(pend_a, EXT_OFS, 2);
                    ADDR_EXT_B:  rd = position_byte(pend_b, EXT_OFS, 2);
                    default:     rd = bus_byte;
                endcase
                bus_byte = rd;
            end
        endcase
        r.read_data = bus_byte;
        r.level_a   = (pwm_count < act_a);
        r.level_b   = (pwm_count < act_b);
        r.drive_en  = status_reg[ENABLE_BIT];
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [7:0] got, logic [7:0] want);
        mismatch_count++;
        if (mismatch_count <= PRINT_CAP)
            $display("mismatch on %s: got %0h, expected %0h, cycle %0d",
                     what, got, want, cycle_count);
    endtask

    // Compare one result word with the oldest prediction
    task automatic check_word(t_servo_word got);
        t_servo_word want;
        if (expected_words.size() == 0) begin
            report_mismatch("unexpected word", got.read_data, 8'h00);
        end else begin
            want = expected_words.pop_front();
            if (got.read_data !== want.read_data)
                report_mismatch("read_data", got.read_data, want.read_data);
            if (got.level_a !== want.level_a)
                report_mismatch("servo_a_level", {7'd0, got.level_a},
                                {7'd0, want.level_a});
            if (got.level_b !== want.level_b)
                report_mismatch("servo_b_level", {7'd0, got.level_b},
                                {7'd0, want.level_b});
            if (got.drive_en !== want.drive_en)
                report_mismatch("drive_enable", {7'd0, got.drive_en},
                                {7'd0, want.drive_en});
        end
    endtask

    // Sample both channels at the rising edge; check before predicting
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (i_rst_n && result_if.valid && result_if.ready)
            check_word({result_if.read_data, result_if.servo_a_level,
                        result_if.servo_b_level, result_if.drive_enable});
        if (i_rst_n && item_if.valid && item_if.ready) begin
            expected_words.push_back(apply_word('{mode: t_mode'(item_if.mode),
                                                  reg_index: item_if.reg_index,
                                                  write_data: item_if.write_data}));
            word_taken = 1'b1;
        end
    end

    // Drive input words from the queue, holding each until it is taken
    always @(negedge i_clk) begin
        was_taken  = word_taken;
        word_taken = 1'b0;
        if (was_taken)
            void'(pending_words.pop_front());
        if (!item_if.valid || was_taken) begin
            if (pending_words.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                item_if.valid      <= 1'b1;
                item_if.mode       <= pending_words[0].mode;
                item_if.reg_index  <= pending_words[0].reg_index;
                item_if.write_data <= pending_words[0].write_data;
            end else begin
                item_if.valid <= 1'b0;
            end
        end
    end

    // Stall the result channel at random
    always @(negedge i_clk) begin
        result_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic push_word(t_mode m, logic [7:0] ri, logic [7:0] wd);
        pending_words.push_back('{mode: m, reg_index: ri, write_data: wd});
    endtask

    // Mostly the low addresses 0 to 7, sometimes any byte
    function automatic logic [7:0] pick_reg();
        if ($urandom_range(99) < 70)
            return 8'($urandom_range(7));
        return 8'($urandom_range(255));
    endfunction

    // Favor small positions so short counts still cross the compares
    function automatic logic [7:0] pick_data(logic [7:0] ri);
        if (ri >= ADDR_STD_A && ri <= ADDR_EXT_B && $urandom_range(99) < 40)
            return 8'($urandom_range(7));
        return 8'($urandom_range(255));
    endfunction

    // Queue a random mix of ticks and bus traffic, pointer/read pairs included
    task automatic run_phase(int n, int tick_pct);
        int          pushed;
        int          pick;
        logic [7:0]  ri;
        pushed = 0;
        while (pushed < n) begin
            ri = pick_reg();
            if ($urandom_range(99) < tick_pct) begin
                push_word(MODE_TICK, 8'($urandom_range(255)), 8'($urandom_range(255)));
                pushed++;
            end else begin
                pick = $urandom_range(99);
                if (pick < 40) begin
                    push_word(MODE_WRITE, ri, pick_data(ri));
                    pushed++;
                end else if (pick < 60) begin
                    push_word(MODE_PTR, ri, 8'($urandom_range(255)));
                    push_word(MODE_READ, 8'($urandom_range(255)), 8'($urandom_range(255)));
                    pushed += 2;
                end else if (pick < 75) begin
                    push_word(MODE_PTR, ri, 8'($urandom_range(255)));
                    pushed++;
                end else begin
                    push_word(MODE_READ, 8'($urandom_range(255)), 8'($urandom_range(255)));
                    pushed++;
                end
            end
        end
    endtask

    // Hold until every queued word is taken and every result is back
    task automatic wait_drained();
        while (pending_words.size() > 0 || expected_words.size() > 0 || item_if.valid)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_pwm_top(logic [15:0] value);
        @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_wdata = value;
        @(negedge i_clk);
        i_cfg_we    = 1'b0;
        servo_top   = value;
    endtask

    // End the run if it hangs
    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("TB_ERROR");
        $finish;
    end

    initial begin
        i_clk              = 1'b0;
        i_rst_n            = 1'b0;
        i_cfg_we           = 1'b0;
        i_cfg_wdata        = 16'd0;
        item_if.valid      = 1'b0;
        item_if.mode       = MODE_TICK;
        item_if.reg_index  = 8'd0;
        item_if.write_data = 8'd0;
        result_if.ready    = 1'b0;

        servo_top  = TOP_RESET;
        pend_a     = CMP_RESET;
        pend_b     = CMP_RESET;
        act_a      = CMP_RESET;
        act_b      = CMP_RESET;
        pwm_count  = 16'd0;
        pwm_down   = 1'b0;
        status_reg = 8'd0;
        read_ptr   = 8'd0;
        bus_byte   = 8'd0;

        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Reset values through reads of status and both position scalings
        push_word(MODE_READ, 8'hFF, 8'hFF);
        push_word(MODE_PTR, ADDR_STD_A, 8'h00);
        push_word(MODE_READ, 8'h00, 8'h00);
        push_word(MODE_PTR, ADDR_EXT_A, 8'h00);
        push_word(MODE_READ, 8'h00, 8'h00);
        // Status byte: full byte stored, enable follows bit 0 only
        push_word(MODE_WRITE, ADDR_STATUS, 8'hFF);
        push_word(MODE_PTR, ADDR_STATUS, 8'h00);
        push_word(MODE_READ, 8'h00, 8'h00);
        push_word(MODE_WRITE, ADDR_STATUS, 8'hFE);
        // Position extremes; read a standard register holding an extended value
        push_word(MODE_WRITE, ADDR_STD_A, 8'h00);
        push_word(MODE_WRITE, ADDR_STD_B, 8'hFF);
        push_word(MODE_WRITE, ADDR_EXT_A, 8'hFF);
        push_word(MODE_WRITE, ADDR_EXT_B, 8'h00);
        push_word(MODE_PTR, ADDR_STD_A, 8'h00);
        push_word(MODE_READ, 8'h00, 8'h00);
        push_word(MODE_PTR, ADDR_STD_B, 8'h00);
        push_word(MODE_READ, 8'h00, 8'h00);
        push_word(MODE_PTR, ADDR_EXT_B, 8'h00);
        push_word(MODE_READ, 8'h00, 8'h00);
        // Unmapped pointer returns the last bus byte; unmapped write changes only it
        push_word(MODE_PTR, 8'hFF, 8'h00);
        push_word(MODE_READ, 8'h00, 8'h00);
        push_word(MODE_WRITE, 8'd200, 8'hAA);
        push_word(MODE_READ, 8'h00, 8'h00);
        push_word(MODE_WRITE, ADDR_STATUS, 8'h01);
        push_word(MODE_TICK, 8'hFF, 8'hFF);
        run_phase(100, 50);
        wait_drained();

        // Top at 1: counter above the turning point comes back down
        set_pwm_top(16'd1);
        run_phase(100, 50);
        wait_drained();

        send_idle_pct  = 79;
        recv_stall_pct = 14;
        set_pwm_top(16'd3);
        run_phase(90, 45);
        // Leave low compares active for the long count that follows
        push_word(MODE_WRITE, ADDR_EXT_A, 8'h00);
        push_word(MODE_WRITE, ADDR_EXT_B, 8'h03);
        for (int k = 0; k < 8; k++)
            push_word(MODE_TICK, 8'($urandom_range(255)), 8'($urandom_range(255)));
        wait_drained();

        // Top at its maximum; pause the sender halfway until all results are in
        set_pwm_top(16'hFFFF);
        run_phase(70, 90);
        wait_drained();
        run_phase(80, 90);
        wait_drained();

        send_idle_pct  = 0;
        recv_stall_pct = 0;
        set_pwm_top(16'd320);
        run_phase(180, 92);
        wait_drained();

        if (mismatch_count == 0 && expected_words.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
